/* hdl/servo_scurve_profile_generator_defines.svh */
// assertion macros shared by the servo profile generator rtl
`ifndef SERVO_SCURVE_PROFILE_GENERATOR_DEFINES_SVH
`define SERVO_SCURVE_PROFILE_GENERATOR_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SSC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define SSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/ssc_pkg.sv */
// shared types, widths and constants of the servo profile generator
package ssc_pkg;

    localparam int CHANNELS_DEF  = 2;
    localparam int MAX_STEPS_DEF = 1000;

    localparam int PULSE_W    = 15;
    localparam int ANGLE_W    = 8;
    localparam int STEP_OUT_W = 10;
    localparam int ACTION_W   = 3;
    localparam int DUR_W      = 20;
    localparam int TICK_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;
    localparam int OPB_W      = 16;
    localparam int RES_W      = 32;

    localparam int Q15_ONE   = 32768;
    localparam int Q15_HALF  = 16384;
    localparam int ANGLE_MAX = 180;
    localparam int ANGLE_MID = 90;
    localparam int DUR_MIN   = 5;
    localparam int TICK_MIN  = 2;

    localparam logic [PULSE_W-1:0] MIN_PULSE_RST  = 15'd500;
    localparam logic [PULSE_W-1:0] MAX_PULSE_RST  = 15'd2500;
    localparam logic [ANGLE_W-1:0] SAFE_MIN_RST   = 8'd0;
    localparam logic [ANGLE_W-1:0] SAFE_MAX_RST   = 8'd180;
    localparam logic [PULSE_W-1:0] CENTER_PULSE_RST = 15'd1500;

    typedef enum logic [ACTION_W-1:0] {
        ACT_WRITE_PULSE = 3'd0,
        ACT_WRITE_ANGLE = 3'd1,
        ACT_START_SWEEP = 3'd2,
        ACT_MOVE        = 3'd3,
        ACT_TICK        = 3'd4
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_PULSE    = 3'd0,
        CFG_MAX_PULSE    = 3'd1,
        CFG_SAFE_MIN     = 3'd2,
        CFG_SAFE_MAX     = 3'd3,
        CFG_CENTER_PULSE = 3'd4
    } t_cfg_idx;

    typedef enum logic {
        OP_MUL = 1'b0,
        OP_DIV = 1'b1
    } t_ssc_op;

    typedef struct packed {
        logic    go;
        t_ssc_op op;
    } t_ssc_req;

endpackage

/* hdl/servo_scurve_profile_generator.sv */
// servo profile generator top level: two-channel pulse widths with quintic sweeps
//
// Input channel (i_in_valid / o_in_stall) carries one action per transaction:
// write pulse, write angle, start sweep, move from the present angle, or tick.
// Every transaction produces exactly one result on the output channel
// (o_out_valid / i_out_stall) with the channel, its compare value, the angle
// read back from it, the sweep step, a last flag and the busy flag.
// The block works on one transaction at a time through a shared bit-serial
// multiply/divide unit. The result sits in an output register; a stalled
// receiver holds it there while the next transaction is already taken and
// worked on, and the block waits only when a second result is ready before
// the first has gone.
// Configuration is written through i_cfg_valid / o_cfg_ready; the user is to
// write it only while the block is idle, which the block itself does not enforce.
// A written centre pulse width is ignored; reset always loads the fixed default.
// Synchronous reset loads the default limits, sets both channels to the
// centre pulse width and cancels any sweep; no clearing pass is needed.
`include "servo_scurve_profile_generator_defines.svh"

module servo_scurve_profile_generator #(
    parameter int CHANNELS  = ssc_pkg::CHANNELS_DEF,
    parameter int MAX_STEPS = ssc_pkg::MAX_STEPS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [ssc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ssc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [ssc_pkg::ACTION_W-1:0]    i_action,
    input  logic                            i_channel,
    input  logic [ssc_pkg::ANGLE_W-1:0]     i_start_angle,
    input  logic [ssc_pkg::ANGLE_W-1:0]     i_target_angle,
    input  logic [ssc_pkg::PULSE_W-1:0]     i_pulse_us,
    input  logic [ssc_pkg::DUR_W-1:0]       i_duration_ms,
    input  logic [ssc_pkg::TICK_W-1:0]      i_tick_ms,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_out_channel,
    output logic [ssc_pkg::PULSE_W-1:0]     o_out_pulse_us,
    output logic [ssc_pkg::ANGLE_W-1:0]     o_readback_angle,
    output logic [ssc_pkg::STEP_OUT_W-1:0]  o_step_index,
    output logic                            o_last,
    output logic                            o_busy_res
);
    import ssc_pkg::*;

    localparam int STEP_W = $clog2(MAX_STEPS + 1);
    localparam int NUM_W  = (STEP_W + 15 > 23) ? STEP_W + 15 : 23;
    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int WIDE_W = PULSE_W + 2;

    typedef enum logic [4:0] {
        S_IDLE, S_DECODE, S_WAIT, S_T_DIV, S_Q_INIT, S_Q_MUL, S_Q_RND, S_SMOOTH,
        S_D_MUL, S_D_END, S_A2P_MUL, S_A2P_DIV, S_A2P_END, S_PUT, S_RB,
        S_P2A_MUL, S_P2A_DIV, S_P2A_END, S_STEPS_DIV, S_SWEEP_INIT, S_OUT
    } t_state;

    // configuration
    logic [PULSE_W-1:0] r_min;
    logic [PULSE_W-1:0] r_max;
    logic [ANGLE_W-1:0] r_smin;
    logic [ANGLE_W-1:0] r_smax;

    // channel and sweep state
    logic [PULSE_W-1:0] r_cv [CHANNELS];
    logic               r_active;
    logic               r_sch;
    logic [ANGLE_W-1:0] r_origin;
    logic [ANGLE_W:0]   r_delta;
    logic [STEP_W-1:0]  r_total;
    logic [STEP_W-1:0]  r_pos;

    // captured transaction
    logic [ACTION_W-1:0] r_action;
    logic                r_ch;
    logic [ANGLE_W-1:0]  r_sa;
    logic [ANGLE_W-1:0]  r_ta;
    logic [PULSE_W-1:0]  r_us;
    logic [DUR_W-1:0]    r_dur;
    logic [TICK_W-1:0]   r_tick;

    // working registers
    t_state             r_state;
    t_state             r_ret;
    t_ssc_req           r_req;
    logic [NUM_W-1:0]   r_opa;
    logic [OPB_W-1:0]   r_opb;
    logic               r_wch;
    logic               r_rep;
    logic [STEP_W-1:0]  r_step;
    logic [STEP_W-1:0]  r_k;
    logic               r_last;
    logic               r_emit;
    logic               r_tick_emit;
    logic [OPB_W-1:0]   r_t;
    logic [OPB_W-1:0]   r_p;
    logic [OPB_W-1:0]   r_p3;
    logic [OPB_W-1:0]   r_p4;
    logic [1:0]         r_qcnt;
    logic [OPB_W-1:0]   r_s;
    logic [ANGLE_W-1:0] r_deg;
    logic [WIDE_W-1:0]  r_pulse;
    logic [ANGLE_W-1:0] r_from;
    logic               r_rb;
    logic [ANGLE_W-1:0] r_angle;

    // output register
    logic                  r_out_valid;
    logic                  r_o_ch;
    logic [PULSE_W-1:0]    r_o_pulse;
    logic [ANGLE_W-1:0]    r_o_angle;
    logic [STEP_OUT_W-1:0] r_o_step;
    logic                  r_o_last;
    logic                  r_o_busy;

    // arithmetic unit
    logic             u_done;
    logic [RES_W-1:0] u_res;

    ssc_serial_unit #(
        .NUM_W (NUM_W)
    ) u_serial (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (r_req),
        .i_opa    (r_opa),
        .i_opb    (r_opb),
        .o_done   (u_done),
        .o_result (u_res)
    );

    logic               c_ch_ok;
    logic [CH_W-1:0]    c_ch_idx;
    logic [CH_W-1:0]    c_rep_idx;
    logic [CH_W-1:0]    c_wch_idx;
    logic [PULSE_W-1:0] c_cv_ch;
    logic [PULSE_W-1:0] c_cv_rep;
    logic               c_span_ok;
    logic [PULSE_W-1:0] c_span;
    logic [ANGLE_W-1:0] c_ta;
    logic [ANGLE_W-1:0] c_sa;
    logic [ANGLE_W-1:0] c_degc;
    logic [WIDE_W-1:0]  c_put_w;
    logic [WIDE_W-1:0]  c_rb_w;
    logic [PULSE_W-1:0] c_diff;
    logic [OPB_W-1:0]   c_qr;
    logic [20:0]        c_sraw;
    logic [OPB_W-1:0]   c_s;
    logic [ANGLE_W-1:0] c_dabs;
    logic [24:0]        c_v;
    logic [24:0]        c_d;
    logic [10:0]        c_a;
    logic [ANGLE_W-1:0] c_acl;
    logic [DUR_W-1:0]   c_dur;
    logic [TICK_W-1:0]  c_tick;
    logic [NUM_W-1:0]   c_steps_q;
    logic [STEP_W-1:0]  c_steps;

    // clamps, conversions and the smoothstep combination
    always_comb begin
        c_ch_ok   = ({31'd0, r_ch} < 32'(CHANNELS));
        c_ch_idx  = CH_W'(r_ch);
        c_rep_idx = CH_W'(r_rep);
        c_wch_idx = CH_W'(r_wch);
        c_cv_ch   = ({31'd0, r_ch} < 32'(CHANNELS)) ? r_cv[c_ch_idx] : '0;
        c_cv_rep  = ({31'd0, r_rep} < 32'(CHANNELS)) ? r_cv[c_rep_idx] : '0;

        c_span_ok = (r_max > r_min);
        c_span    = c_span_ok ? (r_max - r_min) : '0;
        c_ta      = (r_ta > ANGLE_W'(ANGLE_MAX)) ? ANGLE_W'(ANGLE_MAX) : r_ta;
        c_sa      = (r_sa > ANGLE_W'(ANGLE_MAX)) ? ANGLE_W'(ANGLE_MAX) : r_sa;

        // safe angle limits, lower first
        c_degc = r_deg;
        if (c_degc < r_smin) c_degc = r_smin;
        if (c_degc > r_smax) c_degc = r_smax;

        // write clamp, lower first
        c_put_w = r_pulse;
        if (c_put_w < WIDE_W'(r_min)) c_put_w = WIDE_W'(r_min);
        if (c_put_w > WIDE_W'(r_max)) c_put_w = WIDE_W'(r_max);

        // readback clamp into min..max
        c_rb_w = r_pulse;
        if (c_rb_w < WIDE_W'(r_min)) c_rb_w = WIDE_W'(r_min);
        if (c_rb_w > WIDE_W'(r_max)) c_rb_w = WIDE_W'(r_max);
        c_diff = PULSE_W'(c_rb_w - WIDE_W'(r_min));

        // rounded q15 product
        c_qr = OPB_W'((u_res + RES_W'(Q15_HALF)) >> 15);

        // 6 p5 - 15 p4 + 10 p3, clamped to 0..one
        c_sraw = 21'(r_p) * 21'd6 - 21'(r_p4) * 21'd15 + 21'(r_p3) * 21'd10;
        if (c_sraw[20]) begin
            c_s = '0;
        end else if (c_sraw > 21'(Q15_ONE)) begin
            c_s = OPB_W'(Q15_ONE);
        end else begin
            c_s = c_sraw[OPB_W-1:0];
        end

        // signed offset with round-half-up, floor shift
        c_dabs = r_delta[ANGLE_W] ? ANGLE_W'(-r_delta) : r_delta[ANGLE_W-1:0];
        c_v    = r_delta[ANGLE_W] ? -{2'b00, u_res[22:0]} : {2'b00, u_res[22:0]};
        c_v    = c_v + 25'(Q15_HALF);
        c_d    = 25'($signed(c_v) >>> 15);
        c_a    = 11'({3'b000, r_origin}) + c_d[10:0];
        if (c_a[10]) begin
            c_acl = '0;
        end else if (c_a > 11'(ANGLE_MAX)) begin
            c_acl = ANGLE_W'(ANGLE_MAX);
        end else begin
            c_acl = c_a[ANGLE_W-1:0];
        end

        // step count
        c_dur  = (r_dur < DUR_W'(DUR_MIN)) ? DUR_W'(DUR_MIN) : r_dur;
        c_tick = (r_tick < TICK_W'(TICK_MIN)) ? TICK_W'(TICK_MIN) : r_tick;
        c_steps_q = u_res[NUM_W-1:0];
        if (c_steps_q == '0) begin
            c_steps = STEP_W'(1);
        end else if (c_steps_q > NUM_W'(MAX_STEPS)) begin
            c_steps = STEP_W'(MAX_STEPS);
        end else begin
            c_steps = c_steps_q[STEP_W-1:0];
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min  <= MIN_PULSE_RST;
            r_max  <= MAX_PULSE_RST;
            r_smin <= SAFE_MIN_RST;
            r_smax <= SAFE_MAX_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_MIN_PULSE: r_min  <= i_cfg_data;
                CFG_MAX_PULSE: r_max  <= i_cfg_data;
                CFG_SAFE_MIN:  r_smin <= i_cfg_data[ANGLE_W-1:0];
                CFG_SAFE_MAX:  r_smax <= i_cfg_data[ANGLE_W-1:0];
                CFG_CENTER_PULSE: begin
                    // only loaded at reset
                end
                default: begin
                end
            endcase
        end
    end

    // main sequencer with output register
    always_ff @(posedge i_clk) begin
        r_req.go <= 1'b0;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ret       <= S_IDLE;
            r_req       <= '{go: 1'b0, op: OP_MUL};
            r_out_valid <= 1'b0;
            r_active    <= 1'b0;
            r_sch       <= 1'b0;
            r_origin    <= '0;
            r_delta     <= '0;
            r_total     <= '0;
            r_pos       <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_cv[i] <= CENTER_PULSE_RST;
            end
        end else begin
            if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_action    <= i_action;
                        r_ch        <= i_channel;
                        r_sa        <= i_start_angle;
                        r_ta        <= i_target_angle;
                        r_us        <= i_pulse_us;
                        r_dur       <= i_duration_ms;
                        r_tick      <= i_tick_ms;
                        r_rep       <= i_channel;
                        r_wch       <= i_channel;
                        r_step      <= '0;
                        r_last      <= 1'b0;
                        r_emit      <= 1'b0;
                        r_tick_emit <= 1'b0;
                        r_state     <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    if (!c_ch_ok) begin
                        r_pulse <= '0;
                        r_angle <= ANGLE_W'(ANGLE_MID);
                        r_state <= S_OUT;
                    end else begin
                        unique case (t_action'(r_action))
                            ACT_WRITE_PULSE: begin
                                r_active <= 1'b0;
                                r_pulse  <= WIDE_W'(r_us);
                                r_state  <= S_PUT;
                            end
                            ACT_WRITE_ANGLE: begin
                                r_active <= 1'b0;
                                r_deg    <= c_ta;
                                r_state  <= S_A2P_MUL;
                            end
                            ACT_START_SWEEP: begin
                                r_from  <= c_sa;
                                r_state <= S_STEPS_DIV;
                            end
                            ACT_MOVE: begin
                                if (c_span_ok) begin
                                    r_pulse <= WIDE_W'(c_cv_ch);
                                    r_rb    <= 1'b0;
                                    r_state <= S_P2A_MUL;
                                end else begin
                                    r_from  <= '0;
                                    r_state <= S_STEPS_DIV;
                                end
                            end
                            ACT_TICK: begin
                                if (r_active) begin
                                    r_rep       <= r_sch;
                                    r_wch       <= r_sch;
                                    r_step      <= r_pos;
                                    r_k         <= r_pos;
                                    r_emit      <= 1'b1;
                                    r_tick_emit <= 1'b1;
                                    r_state     <= S_T_DIV;
                                end else begin
                                    r_state <= S_RB;
                                end
                            end
                            default: r_state <= S_RB;
                        endcase
                    end
                end
                S_WAIT: begin
                    if (u_done) r_state <= r_ret;
                end
                // sweep setup
                S_STEPS_DIV: begin
                    r_req   <= '{go: 1'b1, op: OP_DIV};
                    r_opa   <= NUM_W'(c_dur);
                    r_opb   <= c_tick;
                    r_ret   <= S_SWEEP_INIT;
                    r_state <= S_WAIT;
                end
                S_SWEEP_INIT: begin
                    r_active    <= 1'b1;
                    r_sch       <= r_ch;
                    r_origin    <= r_from;
                    r_delta     <= {1'b0, c_ta} - {1'b0, r_from};
                    r_total     <= c_steps;
                    r_pos       <= '0;
                    r_k         <= '0;
                    r_emit      <= 1'b1;
                    r_tick_emit <= 1'b0;
                    r_state     <= S_T_DIV;
                end
                // position k: t = one * k / total
                S_T_DIV: begin
                    r_req   <= '{go: 1'b1, op: OP_DIV};
                    r_opa   <= NUM_W'({r_k, 15'd0});
                    r_opb   <= OPB_W'(r_total);
                    r_ret   <= S_Q_INIT;
                    r_state <= S_WAIT;
                end
                S_Q_INIT: begin
                    r_t     <= u_res[OPB_W-1:0];
                    r_p     <= u_res[OPB_W-1:0];
                    r_qcnt  <= '0;
                    r_state <= S_Q_MUL;
                end
                // powers t^2 .. t^5
                S_Q_MUL: begin
                    r_req   <= '{go: 1'b1, op: OP_MUL};
                    r_opa   <= NUM_W'(r_p);
                    r_opb   <= r_t;
                    r_ret   <= S_Q_RND;
                    r_state <= S_WAIT;
                end
                S_Q_RND: begin
                    r_p <= c_qr;
                    if (r_qcnt == 2'd1) r_p3 <= c_qr;
                    if (r_qcnt == 2'd2) r_p4 <= c_qr;
                    if (r_qcnt == 2'd3) begin
                        r_state <= S_SMOOTH;
                    end else begin
                        r_qcnt  <= r_qcnt + 2'd1;
                        r_state <= S_Q_MUL;
                    end
                end
                S_SMOOTH: begin
                    r_s     <= c_s;
                    r_state <= S_D_MUL;
                end
                S_D_MUL: begin
                    r_req   <= '{go: 1'b1, op: OP_MUL};
                    r_opa   <= NUM_W'(c_dabs);
                    r_opb   <= r_s;
                    r_ret   <= S_D_END;
                    r_state <= S_WAIT;
                end
                S_D_END: begin
                    r_deg   <= c_acl;
                    r_state <= S_A2P_MUL;
                end
                // angle to pulse: min + span * deg / 180
                S_A2P_MUL: begin
                    r_req   <= '{go: 1'b1, op: OP_MUL};
                    r_opa   <= NUM_W'(c_span);
                    r_opb   <= OPB_W'(c_degc);
                    r_ret   <= S_A2P_DIV;
                    r_state <= S_WAIT;
                end
                S_A2P_DIV: begin
                    r_req   <= '{go: 1'b1, op: OP_DIV};
                    r_opa   <= u_res[NUM_W-1:0];
                    r_opb   <= OPB_W'(ANGLE_MAX);
                    r_ret   <= S_A2P_END;
                    r_state <= S_WAIT;
                end
                S_A2P_END: begin
                    r_pulse <= WIDE_W'(r_min) + u_res[WIDE_W-1:0];
                    r_state <= S_PUT;
                end
                // write compare value, advance the sweep
                S_PUT: begin
                    r_cv[c_wch_idx] <= c_put_w[PULSE_W-1:0];
                    if (r_emit) begin
                        if (!r_tick_emit) begin
                            r_pos <= STEP_W'(1);
                        end else if (r_pos >= r_total) begin
                            r_active <= 1'b0;
                            r_last   <= 1'b1;
                        end else begin
                            r_pos <= r_pos + 1'b1;
                        end
                    end
                    r_state <= S_RB;
                end
                // readback of the reported channel
                S_RB: begin
                    r_pulse <= WIDE_W'(c_cv_rep);
                    if (!c_span_ok) begin
                        r_angle <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_rb    <= 1'b1;
                        r_state <= S_P2A_MUL;
                    end
                end
                // pulse to angle: (us - min) * 180 / span
                S_P2A_MUL: begin
                    r_req   <= '{go: 1'b1, op: OP_MUL};
                    r_opa   <= NUM_W'(c_diff);
                    r_opb   <= OPB_W'(ANGLE_MAX);
                    r_ret   <= S_P2A_DIV;
                    r_state <= S_WAIT;
                end
                S_P2A_DIV: begin
                    r_req   <= '{go: 1'b1, op: OP_DIV};
                    r_opa   <= u_res[NUM_W-1:0];
                    r_opb   <= OPB_W'(c_span);
                    r_ret   <= S_P2A_END;
                    r_state <= S_WAIT;
                end
                S_P2A_END: begin
                    if (r_rb) begin
                        r_angle <= u_res[ANGLE_W-1:0];
                        r_state <= S_OUT;
                    end else begin
                        r_from  <= u_res[ANGLE_W-1:0];
                        r_state <= S_STEPS_DIV;
                    end
                end
                // hand the result to the output register
                S_OUT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_o_ch      <= r_rep;
                        r_o_pulse   <= r_pulse[PULSE_W-1:0];
                        r_o_angle   <= r_angle;
                        r_o_step    <= STEP_OUT_W'(r_step);
                        r_o_last    <= r_last;
                        r_o_busy    <= r_active;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_cfg_ready      = 1'b1;
    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_out_channel    = r_o_ch;
    assign o_out_pulse_us   = r_o_pulse;
    assign o_readback_angle = r_o_angle;
    assign o_step_index     = r_o_step;
    assign o_last           = r_o_last;
    assign o_busy_res       = r_o_busy;

    // checks
    `SSC_ASSERT_NOW(a_done_in_wait, i_clk, i_rst_n, u_done, r_state == S_WAIT, "unit result outside wait")
    `SSC_ASSERT_NOW(a_pos_in_range, i_clk, i_rst_n, r_active, r_pos <= r_total, "sweep position past total")
    `SSC_ASSERT_NOW(a_total_nonzero, i_clk, i_rst_n, r_active, r_total != '0, "active sweep with no steps")
    `SSC_ASSERT_NOW(a_load_from_out, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state) == S_OUT, "result loaded outside output state")

endmodule

/* hdl/ssc_serial_unit.sv */
// bit-serial shift-add multiplier and restoring divider, one bit per cycle
module ssc_serial_unit #(
    parameter int NUM_W = 25
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  ssc_pkg::t_ssc_req        i_req,
    input  logic [NUM_W-1:0]         i_opa,
    input  logic [ssc_pkg::OPB_W-1:0] i_opb,
    output logic                     o_done,
    output logic [ssc_pkg::RES_W-1:0] o_result
);
    import ssc_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    t_ssc_op          r_op;
    logic [CNT_W-1:0] r_cnt;
    logic [OPB_W-1:0] r_b;
    logic [OPB_W-1:0] r_hi;
    logic [OPB_W-1:0] r_lo;
    logic [NUM_W-1:0] r_q;

    logic [OPB_W:0]   c_sum;
    logic [OPB_W:0]   c_trial;
    logic             c_fit;

    // one multiply step and one divide step
    always_comb begin
        c_sum   = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_b} : '0);
        c_trial = {r_hi, r_q[NUM_W-1]};
        c_fit   = (c_trial >= {1'b0, r_b});
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        r_done <= 1'b0;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.go) begin
            r_busy <= 1'b1;
            r_op   <= i_req.op;
            r_b    <= i_opb;
            r_hi   <= '0;
            r_lo   <= i_opa[OPB_W-1:0];
            r_q    <= i_opa;
            r_cnt  <= (i_req.op == OP_MUL) ? CNT_W'(OPB_W) : CNT_W'(NUM_W);
        end else if (r_busy) begin
            unique case (r_op)
                OP_MUL: begin
                    r_hi <= c_sum[OPB_W:1];
                    r_lo <= {c_sum[0], r_lo[OPB_W-1:1]};
                end
                OP_DIV: begin
                    r_hi <= c_fit ? OPB_W'(c_trial - {1'b0, r_b}) : c_trial[OPB_W-1:0];
                    r_q  <= {r_q[NUM_W-2:0], c_fit};
                end
                default: begin
                end
            endcase
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = (r_op == OP_MUL) ? {r_hi, r_lo} : RES_W'(r_q);

endmodule

/* tb/servo_scurve_profile_generator_checker.sv */
// checker for the servo profile generator: predicts each result and compares it
`timescale 1ns / 100ps

module servo_scurve_profile_generator_checker
    import ssc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_in_valid,
    input  logic                   i_in_stall,
    input  logic [ACTION_W-1:0]    i_action,
    input  logic                   i_channel,
    input  logic [ANGLE_W-1:0]     i_start_angle,
    input  logic [ANGLE_W-1:0]     i_target_angle,
    input  logic [PULSE_W-1:0]     i_pulse_us,
    input  logic [DUR_W-1:0]       i_duration_ms,
    input  logic [TICK_W-1:0]      i_tick_ms,
    input  logic                   i_out_valid,
    input  logic                   i_out_stall,
    input  logic                   i_out_channel,
    input  logic [PULSE_W-1:0]     i_out_pulse_us,
    input  logic [ANGLE_W-1:0]     i_readback_angle,
    input  logic [STEP_OUT_W-1:0]  i_step_index,
    input  logic                   i_last,
    input  logic                   i_busy_res,
    output int                     o_error_count,
    output int                     o_pending_count
);

    typedef struct {
        logic                  channel;
        logic [PULSE_W-1:0]    pulse;
        logic [ANGLE_W-1:0]    angle;
        logic [STEP_OUT_W-1:0] step;
        logic                  last;
        logic                  busy;
    } t_servo_result;

    t_servo_result servo_result_q[$];

    // register copies
    logic [PULSE_W-1:0] min_us, max_us, centre_us;
    logic [ANGLE_W-1:0] safe_lo, safe_hi;

    // channel and sweep state
    logic [PULSE_W-1:0] compare_val [CHANNELS_DEF];
    bit                 sw_active;
    bit                 sw_ch;
    longint             sw_origin, sw_delta, sw_total, sw_pos;

    int error_count;

    assign o_error_count   = error_count;
    assign o_pending_count = servo_result_q.size();

    function automatic longint q15_mul(longint a, longint b);
        return (a * b + Q15_HALF) >>> 15;
    endfunction

    // quintic smoothstep 6t^5 - 15t^4 + 10t^3, clamped to 0..unity
    function automatic longint quintic(longint t);
        longint p2, p3, p4, p5, s;
        p2 = q15_mul(t, t);
        p3 = q15_mul(p2, t);
        p4 = q15_mul(p3, t);
        p5 = q15_mul(p4, t);
        s  = 6 * p5 - 15 * p4 + 10 * p3;
        if (s < 0) s = 0;
        if (s > Q15_ONE) s = Q15_ONE;
        return s;
    endfunction

    function automatic longint deg_to_us(longint deg);
        longint span;
        span = (max_us > min_us) ? longint'(max_us) - longint'(min_us) : 0;
        if (deg < safe_lo) deg = safe_lo;
        if (deg > safe_hi) deg = safe_hi;
        return longint'(min_us) + (span * deg) / ANGLE_MAX;
    endfunction

    function automatic longint us_to_deg(longint us);
        if (max_us <= min_us) return 0;
        if (us < min_us) us = min_us;
        if (us > max_us) us = max_us;
        return ((us - min_us) * ANGLE_MAX) / (longint'(max_us) - longint'(min_us));
    endfunction

    function automatic void load_pulse(bit ch, longint us);
        if (us < min_us) us = min_us;
        if (us > max_us) us = max_us;
        compare_val[ch] = us[PULSE_W-1:0];
    endfunction

    function automatic void load_angle(bit ch, longint deg);
        if (deg > ANGLE_MAX) deg = ANGLE_MAX;
        load_pulse(ch, deg_to_us(deg));
    endfunction

    // position k of the running sweep, rounded half up
    function automatic void drive_position(longint k);
        longint t, v, d, a;
        t = (longint'(Q15_ONE) * k) / sw_total;
        v = sw_delta * quintic(t) + (Q15_ONE >> 1);
        if (v >= 0) d = v >>> 15;
        else d = -(((-v) + 32767) >>> 15);
        a = sw_origin + d;
        if (a < 0) a = 0;
        if (a > ANGLE_MAX) a = ANGLE_MAX;
        load_angle(sw_ch, a);
    endfunction

    function automatic void open_sweep(bit ch, longint from, longint to, longint dur,
                                       longint tick);
        longint steps;
        if (from > ANGLE_MAX) from = ANGLE_MAX;
        if (to > ANGLE_MAX) to = ANGLE_MAX;
        if (dur < DUR_MIN) dur = DUR_MIN;
        if (tick < TICK_MIN) tick = TICK_MIN;
        steps = dur / tick;
        if (steps < 1) steps = 1;
        if (steps > MAX_STEPS_DEF) steps = MAX_STEPS_DEF;
        sw_active = 1'b1;
        sw_ch     = ch;
        sw_origin = from;
        sw_delta  = to - from;
        sw_total  = steps;
        sw_pos    = 0;
        drive_position(0);
        sw_pos    = 1;
    endfunction

    function automatic t_servo_result apply_action();
        t_servo_result r;
        bit            rep;
        r.step = '0;
        r.last = 1'b0;
        rep    = i_channel;
        case (t_action'(i_action))
            ACT_WRITE_PULSE: begin
                sw_active = 1'b0;
                load_pulse(i_channel, i_pulse_us);
            end
            ACT_WRITE_ANGLE: begin
                sw_active = 1'b0;
                load_angle(i_channel, i_target_angle);
            end
            ACT_START_SWEEP: begin
                open_sweep(i_channel, i_start_angle, i_target_angle, i_duration_ms, i_tick_ms);
            end
            ACT_MOVE: begin
                open_sweep(i_channel, us_to_deg(compare_val[i_channel]), i_target_angle,
                           i_duration_ms, i_tick_ms);
            end
            ACT_TICK: begin
                if (sw_active) begin
                    rep    = sw_ch;
                    r.step = sw_pos[STEP_OUT_W-1:0];
                    drive_position(sw_pos);
                    if (sw_pos >= sw_total) begin
                        sw_active = 1'b0;
                        r.last    = 1'b1;
                    end else begin
                        sw_pos++;
                    end
                end
            end
            default: ;
        endcase
        r.channel = rep;
        r.pulse   = compare_val[rep];
        r.angle   = us_to_deg(compare_val[rep]);
        r.busy    = sw_active;
        return r;
    endfunction

    // track registers, predict accepted transactions, compare results
    always @(posedge i_clk) begin
        t_servo_result exp_r;
        if (!i_rst_n) begin
            min_us      = MIN_PULSE_RST;
            max_us      = MAX_PULSE_RST;
            safe_lo     = SAFE_MIN_RST;
            safe_hi     = SAFE_MAX_RST;
            centre_us   = CENTER_PULSE_RST;
            foreach (compare_val[i]) compare_val[i] = centre_us;
            sw_active   = 1'b0;
            sw_ch       = 1'b0;
            sw_origin   = 0;
            sw_delta    = 0;
            sw_total    = 0;
            sw_pos      = 0;
            error_count = 0;
            servo_result_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_MIN_PULSE:    min_us    = i_cfg_data;
                    CFG_MAX_PULSE:    max_us    = i_cfg_data;
                    CFG_SAFE_MIN:     safe_lo   = i_cfg_data[ANGLE_W-1:0];
                    CFG_SAFE_MAX:     safe_hi   = i_cfg_data[ANGLE_W-1:0];
                    CFG_CENTER_PULSE: centre_us = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) servo_result_q.push_back(apply_action());
            if (i_out_valid && !i_out_stall) begin
                if (servo_result_q.size() == 0) begin
                    if (error_count < 10) $display("unexpected result at %0t", $time);
                    error_count++;
                end else begin
                    exp_r = servo_result_q.pop_front();
                    if (i_out_channel !== exp_r.channel || i_out_pulse_us !== exp_r.pulse ||
                        i_readback_angle !== exp_r.angle || i_step_index !== exp_r.step ||
                        i_last !== exp_r.last || i_busy_res !== exp_r.busy) begin
                        if (error_count < 10)
                            $display("mismatch at %0t: exp ch %0d us %0d ang %0d step %0d ",
                                     $time, exp_r.channel, exp_r.pulse, exp_r.angle,
                                     exp_r.step, "last %0d busy %0d / got ch %0d us %0d ",
                                     exp_r.last, exp_r.busy, i_out_channel, i_out_pulse_us,
                                     "ang %0d step %0d last %0d busy %0d", i_readback_angle,
                                     i_step_index, i_last, i_busy_res);
                        error_count++;
                    end
                end
            end
        end
    end

endmodule

/* tb/servo_scurve_profile_generator_tb.sv */
// testbench top of the servo profile generator: stimulus, idling and verdict
`timescale 1ns / 100ps

module servo_scurve_profile_generator_tb;
    import ssc_pkg::*;

    localparam int CYCLE_LIMIT    = 3000000;
    localparam int PHASES         = 5;
    localparam int ITEMS_PER_PHASE = 140;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [ACTION_W-1:0]   i_action = '0;
    logic                  i_channel = 1'b0;
    logic [ANGLE_W-1:0]    i_start_angle = '0;
    logic [ANGLE_W-1:0]    i_target_angle = '0;
    logic [PULSE_W-1:0]    i_pulse_us = '0;
    logic [DUR_W-1:0]      i_duration_ms = '0;
    logic [TICK_W-1:0]     i_tick_ms = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic                  o_out_channel;
    logic [PULSE_W-1:0]    o_out_pulse_us;
    logic [ANGLE_W-1:0]    o_readback_angle;
    logic [STEP_OUT_W-1:0] o_step_index;
    logic                  o_last;
    logic                  o_busy_res;

    int error_count, pending_count;
    int idle_pct = 0;
    int stall_pct = 0;
    int items_sent;
    int cycle_count = 0;

    servo_scurve_profile_generator u_top (.*);

    servo_scurve_profile_generator_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index,
        .i_cfg_data, .i_in_valid, .i_in_stall(o_in_stall), .i_action, .i_channel,
        .i_start_angle, .i_target_angle, .i_pulse_us, .i_duration_ms, .i_tick_ms,
        .i_out_valid(o_out_valid), .i_out_stall, .i_out_channel(o_out_channel),
        .i_out_pulse_us(o_out_pulse_us), .i_readback_angle(o_readback_angle),
        .i_step_index(o_step_index), .i_last(o_last), .i_busy_res(o_busy_res),
        .o_error_count(error_count), .o_pending_count(pending_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_txn(logic [ACTION_W-1:0] act, logic ch, logic [ANGLE_W-1:0] sa,
                            logic [ANGLE_W-1:0] ta, logic [PULSE_W-1:0] us,
                            logic [DUR_W-1:0] dur, logic [TICK_W-1:0] tick);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_action       <= act;
        i_channel      <= ch;
        i_start_angle  <= sa;
        i_target_angle <= ta;
        i_pulse_us     <= us;
        i_duration_ms  <= dur;
        i_tick_ms      <= tick;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // quiet the input channel and let every expected result drain
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic load_limits(int set_no);
        case (set_no)
            0: begin
                write_reg(CFG_MIN_PULSE, 15'd500);
                write_reg(CFG_MAX_PULSE, 15'd2500);
                write_reg(CFG_SAFE_MIN, 15'd0);
                write_reg(CFG_SAFE_MAX, 15'd180);
                write_reg(CFG_CENTER_PULSE, 15'd1500);
            end
            1: begin
                write_reg(CFG_MIN_PULSE, 15'd0);
                write_reg(CFG_MAX_PULSE, 15'd19999);
                write_reg(CFG_SAFE_MIN, 15'd30);
                write_reg(CFG_SAFE_MAX, 15'd150);
                write_reg(CFG_CENTER_PULSE, 15'h7FFF);
            end
            2: begin
                // inverted span and inverted safe window
                write_reg(CFG_MIN_PULSE, 15'd2000);
                write_reg(CFG_MAX_PULSE, 15'd1000);
                write_reg(CFG_SAFE_MIN, 15'd120);
                write_reg(CFG_SAFE_MAX, 15'd60);
            end
            3: begin
                // empty span, upper bits of the angle registers set
                write_reg(CFG_MIN_PULSE, 15'd1200);
                write_reg(CFG_MAX_PULSE, 15'd1200);
                write_reg(CFG_SAFE_MIN, 15'h7F00);
                write_reg(CFG_SAFE_MAX, 15'd255);
                write_reg(CFG_CENTER_PULSE, 15'd0);
            end
            default: begin
                write_reg(CFG_MIN_PULSE, 15'd19999);
                write_reg(CFG_MAX_PULSE, 15'h7FFF);
                write_reg(CFG_SAFE_MIN, 15'd180);
                write_reg(CFG_SAFE_MAX, 15'd180);
            end
        endcase
    endtask

    // sweep start with random content followed by a run of ticks
    task automatic sweep_sequence();
        logic [DUR_W-1:0]  dur;
        logic [TICK_W-1:0] tick;
        int                n_ticks;
        logic              ch;
        ch   = $urandom_range(1);
        dur  = ($urandom_range(9) == 0) ? DUR_W'($urandom) : DUR_W'($urandom_range(40));
        tick = ($urandom_range(9) == 0) ? TICK_W'($urandom) : TICK_W'($urandom_range(12));
        send_txn(($urandom_range(1) == 0) ? ACT_START_SWEEP : ACT_MOVE, ch,
                 ANGLE_W'($urandom), ANGLE_W'($urandom), PULSE_W'($urandom), dur, tick);
        n_ticks = $urandom_range(1, 14);
        for (int i = 0; i < n_ticks; i++)
            send_txn(ACT_TICK, ($urandom_range(3) == 0) ? ~ch : ch, ANGLE_W'($urandom),
                     ANGLE_W'($urandom), PULSE_W'($urandom), DUR_W'($urandom),
                     TICK_W'($urandom));
    endtask

    task automatic noise_txn();
        send_txn(ACTION_W'($urandom), $urandom_range(1), ANGLE_W'($urandom),
                 ANGLE_W'($urandom), PULSE_W'($urandom), DUR_W'($urandom),
                 TICK_W'($urandom));
    endtask

    task automatic directed_items();
        send_txn(ACT_WRITE_PULSE, 1'b0, 8'd0, 8'd0, 15'd0, 20'd0, 16'd0);
        send_txn(ACT_WRITE_PULSE, 1'b1, 8'd0, 8'd0, 15'h7FFF, 20'd0, 16'd0);
        send_txn(ACT_WRITE_ANGLE, 1'b0, 8'd0, 8'd0, 15'd0, 20'd0, 16'd0);
        send_txn(ACT_WRITE_ANGLE, 1'b1, 8'd0, 8'd255, 15'd0, 20'd0, 16'd0);
        // tick with no sweep running
        send_txn(ACT_TICK, 1'b1, 8'd0, 8'd0, 15'd0, 20'd0, 16'd0);
        // minimum duration and tick: two steps
        send_txn(ACT_START_SWEEP, 1'b0, 8'd0, 8'd180, 15'd0, 20'd0, 16'd0);
        send_txn(ACT_TICK, 1'b1, 8'd0, 8'd0, 15'd0, 20'd0, 16'd0);
        send_txn(ACT_TICK, 1'b0, 8'd0, 8'd0, 15'd0, 20'd0, 16'd0);
        send_txn(ACT_TICK, 1'b0, 8'd0, 8'd0, 15'd0, 20'd0, 16'd0);
        // downward sweep from an over-range start
        send_txn(ACT_START_SWEEP, 1'b1, 8'd255, 8'd0, 15'd0, 20'hFFFFF, 16'hFFFF);
        send_txn(ACT_TICK, 1'b0, 8'd0, 8'd0, 15'd0, 20'd0, 16'd0);
        send_txn(ACT_TICK, 1'b1, 8'd0, 8'd0, 15'd0, 20'd0, 16'd0);
        // new sweep replaces the running one, single step
        send_txn(ACT_MOVE, 1'b0, 8'd0, 8'd45, 15'd0, 20'd10, 16'hFFFF);
        send_txn(ACT_TICK, 1'b0, 8'd0, 8'd0, 15'd0, 20'd0, 16'd0);
        send_txn(ACT_TICK, 1'b0, 8'd0, 8'd0, 15'd0, 20'd0, 16'd0);
        // step count clamped to its maximum, then aborted by a direct write
        send_txn(ACT_START_SWEEP, 1'b1, 8'd10, 8'd170, 15'd0, 20'hFFFFF, 16'd2);
        send_txn(ACT_TICK, 1'b1, 8'd0, 8'd0, 15'd0, 20'd0, 16'd0);
        send_txn(ACT_WRITE_PULSE, 1'b0, 8'd0, 8'd0, 15'd1700, 20'd0, 16'd0);
        send_txn(ACT_TICK, 1'b1, 8'd0, 8'd0, 15'd0, 20'd0, 16'd0);
        // unused action codes
        send_txn(3'd5, 1'b0, 8'hFF, 8'hFF, 15'h7FFF, 20'hFFFFF, 16'hFFFF);
        send_txn(3'd7, 1'b1, 8'd0, 8'd0, 15'd0, 20'd0, 16'd0);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        load_limits(0);
        items_sent = 0;
        directed_items();
        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph != 0) begin
                settle();
                load_limits(ph);
            end
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 58; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 58; end
                default: begin idle_pct = 19; stall_pct = 19; end
            endcase
            items_sent = 0;
            while (items_sent < ITEMS_PER_PHASE) begin
                if ($urandom_range(9) < 7) sweep_sequence();
                else noise_txn();
            end
        end
        settle();
        repeat (300) @(posedge i_clk);
        if (error_count == 0 && pending_count == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

endmodule
